// ===== hdl/hrs_pkg.sv =====
`default_nettype none
package hrs_pkg;

   // Result codes
   typedef enum logic [1:0] {
      OUTCOME_OK         = 2'd0,
      OUTCOME_READ_ERROR = 2'd1,
      OUTCOME_MISMATCH   = 2'd2
   } outcome_type;

   // Configuration register indexes
   localparam logic CSR_EXPECTED_STATUS  = 1'b0;
   localparam logic CSR_MAX_HEADER_BYTES = 1'b1;

   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 10;
   localparam int LIMIT_W    = 16;
   localparam int COUNT_W    = 17;
   localparam int LENGTH_W   = 54;
   localparam int WINDOW_W   = 32;
   localparam int MATCH_W    = 5;
   localparam int CSR_DATA_W = 16;

   localparam logic [STATUS_W-1:0] STATUS_RESET = 10'd200;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 16'd16384;
   localparam logic [WINDOW_W-1:0] PATTERN_RESET = 32'h3230_3020;

   localparam logic [WINDOW_W-1:0] TERMINATOR_WORD   = 32'h0D0A_0D0A;
   localparam logic [COUNT_W-1:0]  STATUS_CHECK_BYTE = 17'd13;
   localparam logic [LENGTH_W-1:0] LENGTH_GUARD      = 54'd450359962737049;
   localparam logic [MATCH_W-1:0]  PREFIX_LEN        = 5'd16;

   localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

   // One scan step's result
   typedef struct packed {
      logic                valid;
      outcome_type         outcome;
      logic [LENGTH_W-1:0] length;
   } scan_result_type;

   // "Content-Length: " one character per position
   function automatic logic [BYTE_W-1:0] prefix_char(input logic [3:0] pos);
      logic [BYTE_W-1:0] ch;
      case (pos)
         4'd0:    ch = 8'h43; // C
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h4C; // L
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         4'd14:   ch = 8'h3A; // :
         4'd15:   ch = 8'h20; // space
         default: ch = 8'h20;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/hrs_csr.sv =====
`default_nettype none
module hrs_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic                             csr_index,
   input  wire logic [hrs_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic      [hrs_pkg::LIMIT_W-1:0]      max_bytes,
   output logic      [hrs_pkg::WINDOW_W-1:0]     status_pattern
);

   logic [hrs_pkg::STATUS_W-1:0] status_ff;
   logic [hrs_pkg::LIMIT_W-1:0]  limit_ff;
   logic [3:0]                   hundreds_ff;
   logic [3:0]                   hundreds_in;
   logic [6:0]                   rest_ff;
   logic [6:0]                   rest_in;
   logic [hrs_pkg::WINDOW_W-1:0] pattern_ff;
   logic [hrs_pkg::WINDOW_W-1:0] pattern_in;
   logic [15:0]                  hund_prod;
   logic [10:0]                  rest_wide;
   logic [14:0]                  tens_prod;
   logic [3:0]                   tens;
   logic [3:0]                   ones;
   logic [7:0]                   ones_wide;

   // Split status into hundreds and remainder (x*41 >> 12 is x/100 here)
   always_comb begin
      hund_prod   = {6'd0, status_ff} * 16'd41;
      hundreds_in = hund_prod[15:12];
      rest_wide   = {1'b0, status_ff} - (11'(hundreds_in) * 11'd100);
      rest_in     = rest_wide[6:0];
   end

   // Split remainder into tens and ones (x*205 >> 11 is x/10 here)
   always_comb begin
      tens_prod  = {8'd0, rest_ff} * 15'd205;
      tens       = tens_prod[14:11];
      ones_wide  = {1'b0, rest_ff} - (8'(tens) * 8'd10);
      ones       = ones_wide[3:0];
      pattern_in = {hrs_pkg::CHAR_ZERO + 8'(hundreds_ff),
                    hrs_pkg::CHAR_ZERO + 8'(tens),
                    hrs_pkg::CHAR_ZERO + 8'(ones),
                    hrs_pkg::CHAR_SPACE};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff   <= hrs_pkg::STATUS_RESET;
         limit_ff    <= hrs_pkg::LIMIT_RESET;
         hundreds_ff <= 4'd2;
         rest_ff     <= 7'd0;
         pattern_ff  <= hrs_pkg::PATTERN_RESET;
      end else begin
         if (csr_write && csr_index == hrs_pkg::CSR_EXPECTED_STATUS) begin
            status_ff <= csr_wdata[hrs_pkg::STATUS_W-1:0];
         end
         if (csr_write && csr_index == hrs_pkg::CSR_MAX_HEADER_BYTES) begin
            limit_ff <= csr_wdata[hrs_pkg::LIMIT_W-1:0];
         end
         hundreds_ff <= hundreds_in;
         rest_ff     <= rest_in;
         pattern_ff  <= pattern_in;
      end
   end

   assign max_bytes      = limit_ff;
   assign status_pattern = pattern_ff;

endmodule
`default_nettype wire

// ===== hdl/hrs_scan.sv =====
`default_nettype none
module hrs_scan (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire logic [hrs_pkg::BYTE_W-1:0]     rx_byte,
   input  wire logic                           read_failed,
   input  wire logic [hrs_pkg::LIMIT_W-1:0]    max_bytes,
   input  wire logic [hrs_pkg::WINDOW_W-1:0]   status_pattern,
   output hrs_pkg::scan_result_type            result
);

   logic [hrs_pkg::WINDOW_W-1:0] window_ff,   window_in;
   logic [hrs_pkg::COUNT_W-1:0]  seen_ff,     seen_in;
   logic                         matched_ff,  matched_in;
   logic [hrs_pkg::LENGTH_W-1:0] length_ff,   length_in;
   logic [hrs_pkg::MATCH_W-1:0]  match_ff,    match_in;
   logic                         digits_ff,   digits_in;
   logic                         line_ff,     line_in;
   logic                         is_digit;
   logic                         clear;
   logic [hrs_pkg::LENGTH_W-1:0] length_x10;

   assign is_digit   = (rx_byte >= hrs_pkg::CHAR_ZERO) && (rx_byte <= hrs_pkg::CHAR_NINE);
   assign length_x10 = (length_ff << 3) + (length_ff << 1)
                     + {{(hrs_pkg::LENGTH_W-4){1'b0}}, rx_byte[3:0]};

   // Next scan state and result for the byte at hand
   always_comb begin
      window_in  = {window_ff[hrs_pkg::WINDOW_W-9:0], rx_byte};
      seen_in    = seen_ff + 17'd1;
      matched_in = matched_ff;
      length_in  = length_ff;
      match_in   = match_ff;
      digits_in  = digits_ff;
      line_in    = line_ff;
      result     = '{valid: 1'b0, outcome: hrs_pkg::OUTCOME_OK, length: '0};
      clear      = 1'b0;

      if (read_failed) begin
         result = '{valid: 1'b1, outcome: hrs_pkg::OUTCOME_READ_ERROR, length: '0};
         clear  = 1'b1;
      end else if (seen_in > {1'b0, max_bytes}) begin
         result = '{valid: 1'b1, outcome: hrs_pkg::OUTCOME_READ_ERROR, length: '0};
         clear  = 1'b1;
      end else begin
         if (seen_in == hrs_pkg::STATUS_CHECK_BYTE) begin
            matched_in = (window_in == status_pattern);
         end

         // Digit accumulation, or prefix match at line start
         if (digits_ff) begin
            if (is_digit) begin
               if ($signed(length_ff) > $signed(hrs_pkg::LENGTH_GUARD)) begin
                  digits_in = 1'b0;
               end else begin
                  length_in = length_x10;
               end
            end else begin
               digits_in = 1'b0;
            end
         end else if (line_ff) begin
            match_in = (rx_byte == hrs_pkg::prefix_char(4'd0)) ? 5'd1 : 5'd0;
            line_in  = 1'b0;
         end else if (match_ff != 5'd0 && match_ff < hrs_pkg::PREFIX_LEN) begin
            if (rx_byte == hrs_pkg::prefix_char(match_ff[3:0])) begin
               match_in = match_ff + 5'd1;
               if (match_in == hrs_pkg::PREFIX_LEN) begin
                  digits_in = 1'b1;
                  length_in = '0;
               end
            end else begin
               match_in = 5'd0;
            end
         end

         if (rx_byte == hrs_pkg::CHAR_LF) begin
            line_in = 1'b1;
         end

         // End of header
         if (window_in == hrs_pkg::TERMINATOR_WORD) begin
            clear = 1'b1;
            if (matched_in) begin
               result = '{valid: 1'b1, outcome: hrs_pkg::OUTCOME_OK, length: length_in};
            end else begin
               result = '{valid: 1'b1, outcome: hrs_pkg::OUTCOME_MISMATCH, length: '0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && clear)) begin
         window_ff  <= '0;
         seen_ff    <= '0;
         matched_ff <= 1'b0;
         length_ff  <= '1;
         match_ff   <= '0;
         digits_ff  <= 1'b0;
         line_ff    <= 1'b1;
      end else if (step) begin
         window_ff  <= window_in;
         seen_ff    <= seen_in;
         matched_ff <= matched_in;
         length_ff  <= length_in;
         match_ff   <= match_in;
         digits_ff  <= digits_in;
         line_ff    <= line_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/http_response_header_scanner_core.sv =====
// HTTP response header scanner. Takes one header byte per transaction on the
// req_ channel and returns at most one rsp_ transaction per header: outcome
// (ok, read error or byte limit, status mismatch) and the parsed
// Content-Length (-1 when absent), issued on the byte that completes
// CR LF CR LF, on a read failure, or when the byte limit is passed; the scan
// then restarts. A byte is taken every cycle unless a stalled result blocks
// the held byte: it is held in the input register, is processed by the
// combinational scan update and lands in the result register.
// The status pattern is rebuilt from expected_status through the
// hundreds/remainder registers and the pattern register after a csr_ write.
`default_nettype none
module http_response_header_scanner_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [7:0]                          req_rx_byte,
   input  wire logic                                req_read_failed,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [1:0]                          rsp_outcome,
   output logic signed [53:0]                       rsp_content_length,
   input  wire logic                                csr_write,
   input  wire logic                                csr_index,
   input  wire logic [15:0]                         csr_wdata
);

   logic                               in_valid_ff;
   logic [hrs_pkg::BYTE_W-1:0]         in_byte_ff;
   logic                               in_fail_ff;
   logic                               advance;
   logic [hrs_pkg::LIMIT_W-1:0]        max_bytes;
   logic [hrs_pkg::WINDOW_W-1:0]       status_pattern;
   hrs_pkg::scan_result_type           result;
   logic                               out_valid_ff;
   hrs_pkg::outcome_type               out_outcome_ff;
   logic [hrs_pkg::LENGTH_W-1:0]       out_length_ff;

   hrs_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .max_bytes      (max_bytes),
      .status_pattern (status_pattern)
   );

   hrs_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .rx_byte        (in_byte_ff),
      .read_failed    (in_fail_ff),
      .max_bytes      (max_bytes),
      .status_pattern (status_pattern),
      .result         (result)
   );

   // Advance the held byte when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_rx_byte;
         in_fail_ff <= req_read_failed;
      end
   end

   // Result register: load on a result, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && result.valid) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && result.valid) begin
         out_outcome_ff <= result.outcome;
         out_length_ff  <= result.length;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_outcome        = out_outcome_ff;
   assign rsp_content_length = $signed(out_length_ff);

endmodule
`default_nettype wire

// ===== hdl/hrs_checker.sv =====
`default_nettype none
module hrs_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [1:0]         rsp_outcome,
   input wire logic signed [53:0] rsp_content_length
);

   // Hold a stalled result
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_outcome)
                                    && $stable(rsp_content_length);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   // Only defined outcome codes leave the block
   property p_outcome_code;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_outcome == hrs_pkg::OUTCOME_OK
                        || rsp_outcome == hrs_pkg::OUTCOME_READ_ERROR
                        || rsp_outcome == hrs_pkg::OUTCOME_MISMATCH);
   endproperty
   a_outcome_code: assert property (p_outcome_code) else $error("undefined outcome");

   // Failed scans carry a zero length
   property p_fail_length;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_outcome != hrs_pkg::OUTCOME_OK |-> rsp_content_length == 54'sd0;
   endproperty
   a_fail_length: assert property (p_fail_length) else $error("failure with nonzero length");

   // Good scans carry -1 or a non-negative length
   property p_ok_length;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_outcome == hrs_pkg::OUTCOME_OK |-> rsp_content_length >= -54'sd1;
   endproperty
   a_ok_length: assert property (p_ok_length) else $error("length below -1");

endmodule

bind http_response_header_scanner_core hrs_checker u_hrs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_outcome        (rsp_outcome),
   .rsp_content_length (rsp_content_length)
);
`default_nettype wire
